>>> sv/gld_pkg.sv
`default_nettype none
package gld_pkg;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned CMD_W    = 1;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BUF_W    = 24;
    localparam int unsigned BCNT_W   = 5;
    localparam int unsigned MIN_SIZE = 2;
    localparam int unsigned MAX_SIZE = 8;

    localparam logic [CMD_W-1:0] CMD_FEED = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_EXTRACT,
        ST_WALK,
        ST_WALK_WAIT,
        ST_POP,
        ST_POP_WAIT,
        ST_RESP
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic restart;
        logic feed;
        logic extract;
        logic walk_issue;
        logic walk_step;
        logic pop_issue;
        logic resp_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic stack_empty;
        logic finished;
        logic enough_bits;
        logic walk_more;
        logic walk_active;
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              symbol_valid;
        logic              need_byte;
        logic              end_of_image;
        logic              error_flag;
    } t_result;
endpackage
`default_nettype wire

>>> sv/gld_if.sv
`default_nettype none
interface gld_in_if;
    logic                      valid;
    logic                      ready;
    logic [gld_pkg::CMD_W-1:0] cmd;
    logic [gld_pkg::BYTE_W-1:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface gld_out_if;
    logic                       valid;
    logic                       ready;
    logic [gld_pkg::BYTE_W-1:0] symbol;
    logic                       symbol_valid;
    logic                       need_byte;
    logic                       end_of_image;
    logic                       error_flag;
    modport source (output valid, output symbol, output symbol_valid, output need_byte,
                    output end_of_image, output error_flag, input ready);
    modport sink   (input valid, input symbol, input symbol_valid, input need_byte,
                    input end_of_image, input error_flag, output ready);
endinterface
`default_nettype wire

>>> sv/gld_ctrl.sv
`default_nettype none
module gld_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_req_valid,
    input  wire logic            i_req_cmd,
    input  wire logic            i_res_ready,
    input  wire gld_pkg::t_status i_status,
    output gld_pkg::t_cmd        o_cmd,
    output logic                 o_req_ready,
    output logic                 o_res_valid
);
    import gld_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_cmd.restart = i_cfg_we;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = (i_req_cmd == CMD_PULL) ? ST_EXTRACT : ST_FEED;
                end
            end
            ST_FEED: begin
                o_cmd.feed      = 1'b1;
                o_cmd.resp_load = 1'b1;
                n_state         = ST_RESP;
            end
            ST_EXTRACT: begin
                priority if (!i_status.stack_empty) begin
                    o_cmd.pop_issue = 1'b1;
                    n_state         = ST_POP;
                end else if (!i_status.finished && i_status.enough_bits) begin
                    o_cmd.extract = 1'b1;
                    n_state       = ST_WALK;
                end else begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = ST_RESP;
                end
            end
            ST_WALK: begin
                if (i_status.walk_active) begin
                    o_cmd.walk_issue = 1'b1;
                    n_state          = ST_WALK_WAIT;
                end else begin
                    n_state = ST_EXTRACT;
                end
            end
            ST_WALK_WAIT: begin
                o_cmd.walk_step = 1'b1;
                n_state         = ST_WALK;
            end
            ST_POP:      n_state = ST_POP_WAIT;
            ST_POP_WAIT: begin
                o_cmd.resp_load = 1'b1;
                n_state         = ST_RESP;
            end
            ST_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    ap_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");
    ap_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid)
        else $error("result dropped");
    ap_pop_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |=> (r_state == ST_POP_WAIT))
        else $error("pop path broken");
endmodule
`default_nettype wire

>>> sv/gld_dpath.sv
`default_nettype none
module gld_dpath #(
    parameter int unsigned MAX_CODE_BITS = 12,
    parameter int unsigned TABLE_DEPTH   = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [gld_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [gld_pkg::BYTE_W-1:0] i_data_byte,
    input  wire gld_pkg::t_cmd              i_cmd,
    output gld_pkg::t_status                o_status,
    output gld_pkg::t_result                o_result
);
    import gld_pkg::*;

    localparam int unsigned AW  = $clog2(TABLE_DEPTH);
    localparam int unsigned NW  = AW + 1;
    localparam int unsigned CWW = 4;

    logic [CFG_W-1:0]  r_min;
    logic [BUF_W-1:0]  r_buf;
    logic [BCNT_W-1:0] r_bcnt;
    logic [CWW-1:0]    r_cw;
    logic [NW-1:0]     r_next;
    logic [AW-1:0]     r_prev;
    logic [7:0]        r_pfirst;
    logic              r_after_clear;
    logic              r_finished;
    logic [NW-1:0]     r_sp;
    logic              r_err;
    logic              r_popped;
    // expansion walk
    logic              r_walk;
    logic [AW-1:0]     r_x;
    logic [AW-1:0]     r_code;
    logic              r_add;
    logic [7:0]        r_pop_data;
    logic [11:0]       r_rd_pre;
    logic [7:0]        r_rd_suf;
    t_result           r_res;

    logic [11:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]  suffix_mem [TABLE_DEPTH];
    logic [7:0]  stack_mem  [TABLE_DEPTH];

    logic [3:0]   eff_min;
    logic [NW-1:0] clear_code;
    logic [NW-1:0] code_val;
    logic [NW-1:0] x_ext;
    logic         x_chain;
    logic         push_en;
    logic [7:0]   push_val;
    logic         tab_we;
    logic         known_new;
    logic         feed_take;
    logic [BCNT_W-1:0] bcnt_after;

    always_comb begin
        eff_min = (r_min < CFG_W'(MIN_SIZE)) ? 4'(MIN_SIZE)
                : (r_min > CFG_W'(MAX_SIZE)) ? 4'(MAX_SIZE) : r_min;
        clear_code = NW'(1) << eff_min;
        code_val   = NW'(r_buf & ((BUF_W'(1) << r_cw) - BUF_W'(1)));
        x_ext      = {1'b0, r_x};
        x_chain    = x_ext > clear_code + NW'(1);
        feed_take  = !r_finished && (r_bcnt < BCNT_W'(r_cw));
        bcnt_after = feed_take ? r_bcnt + BCNT_W'(8) : r_bcnt;
    end

    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.finished    = r_finished;
    assign o_status.enough_bits = (r_bcnt >= BCNT_W'(r_cw));
    assign o_status.walk_more   = x_chain;
    assign o_status.walk_active = r_walk;
    assign o_result             = r_res;

    // Pushes: previous first symbol for a code not yet in the table, suffix
    // entries during the walk, final root symbol at the end.
    always_comb begin
        push_en   = 1'b0;
        push_val  = '0;
        tab_we    = 1'b0;
        known_new = i_cmd.extract && !r_after_clear && (code_val == r_next);
        if (known_new) begin
            push_en  = (r_sp < NW'(TABLE_DEPTH));
            push_val = r_pfirst;
        end else if (i_cmd.walk_step && r_walk) begin
            push_en  = (r_sp < NW'(TABLE_DEPTH));
            push_val = x_chain ? r_rd_suf : r_x[7:0];
            tab_we   = !x_chain && r_add && (r_next < NW'(TABLE_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pre <= prefix_mem[r_x];
        r_rd_suf <= suffix_mem[r_x];
        if (push_en) stack_mem[r_sp[AW-1:0]] <= push_val;
        if (i_cmd.pop_issue) r_pop_data <= stack_mem[r_sp[AW-1:0] - AW'(1)];
        if (tab_we) begin
            prefix_mem[r_next[AW-1:0]] <= 12'(r_prev);
            suffix_mem[r_next[AW-1:0]] <= r_x[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            if (!i_rst_n) r_min <= CFG_W'(MAX_SIZE);
            else          r_min <= i_cfg_data;
            r_buf         <= '0;
            r_bcnt        <= '0;
            r_cw          <= (!i_rst_n) ? CWW'(MAX_SIZE + 1) : CWW'(
                             (i_cfg_data < CFG_W'(MIN_SIZE)) ? 4'(MIN_SIZE) :
                             (i_cfg_data > CFG_W'(MAX_SIZE)) ? 4'(MAX_SIZE) : i_cfg_data)
                             + CWW'(1);
            r_next        <= (!i_rst_n) ? NW'((1 << MAX_SIZE) + 2) : (NW'(1) << (
                             (i_cfg_data < CFG_W'(MIN_SIZE)) ? 4'(MIN_SIZE) :
                             (i_cfg_data > CFG_W'(MAX_SIZE)) ? 4'(MAX_SIZE) : i_cfg_data))
                             + NW'(2);
            r_prev        <= '0;
            r_pfirst      <= '0;
            r_after_clear <= 1'b1;
            r_finished    <= 1'b0;
            r_sp          <= '0;
            r_err         <= 1'b0;
            r_popped      <= 1'b0;
            r_walk        <= 1'b0;
            r_res         <= '0;
        end else begin
            if (i_cmd.feed && feed_take) begin
                r_buf  <= r_buf | (BUF_W'(i_data_byte) << r_bcnt);
                r_bcnt <= bcnt_after;
            end
            if (i_cmd.extract) begin
                r_buf  <= r_buf >> r_cw;
                r_bcnt <= r_bcnt - BCNT_W'(r_cw);
                r_code <= code_val[AW-1:0];
                r_add  <= 1'b0;
                priority if (code_val == clear_code) begin
                    r_cw          <= CWW'(eff_min) + CWW'(1);
                    r_next        <= clear_code + NW'(2);
                    r_after_clear <= 1'b1;
                end else if (code_val == clear_code + NW'(1)) begin
                    r_finished <= 1'b1;
                end else if (r_after_clear) begin
                    if (code_val > clear_code) begin
                        r_err <= 1'b1;
                    end else begin
                        r_x           <= code_val[AW-1:0];
                        r_walk        <= 1'b1;
                        r_after_clear <= 1'b0;
                    end
                end else if (code_val > r_next || code_val >= NW'(TABLE_DEPTH)) begin
                    r_err <= 1'b1;
                end else if (code_val == r_next) begin
                    if (push_en) r_sp <= r_sp + NW'(1);
                    r_x    <= r_prev;
                    r_walk <= 1'b1;
                    r_add  <= 1'b1;
                end else begin
                    r_x    <= code_val[AW-1:0];
                    r_walk <= 1'b1;
                    r_add  <= 1'b1;
                end
            end
            if (i_cmd.walk_step && r_walk) begin
                if (push_en) r_sp <= r_sp + NW'(1);
                if (x_chain) begin
                    r_x <= r_rd_pre[AW-1:0];
                end else begin
                    r_walk   <= 1'b0;
                    r_prev   <= r_code;
                    r_pfirst <= r_x[7:0];
                    if (tab_we) begin
                        r_next <= r_next + NW'(1);
                        if (r_next + NW'(1) == (NW'(1) << r_cw)
                            && r_cw < CWW'(MAX_CODE_BITS)) begin
                            r_cw <= r_cw + CWW'(1);
                        end
                    end
                end
            end
            if (i_cmd.pop_issue) begin
                r_sp     <= r_sp - NW'(1);
                r_popped <= 1'b1;
            end
            if (i_cmd.resp_load) begin
                r_res.symbol_valid <= r_popped;
                r_res.symbol       <= r_popped ? r_pop_data : '0;
                r_res.need_byte    <= !r_finished && (r_sp == '0)
                                      && ((i_cmd.feed ? bcnt_after : r_bcnt)
                                          < BCNT_W'(r_cw));
                r_res.end_of_image <= r_finished && (r_sp == '0);
                r_res.error_flag   <= i_cmd.feed ? (!r_finished
                                      && r_bcnt >= BCNT_W'(r_cw)) : r_err;
                r_err              <= 1'b0;
                r_popped           <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/gif_lzw_decoder.sv
// Feed: accept the request, load the byte and present the result.
// Pull: when the stack holds symbols, accept, pop and present the result; each code taken on
// the way adds an extract step and a prefix-chain walk, with a step per symbol pushed, the table
// memory being read once per step. The next request is accepted after the result goes.
// Synchronous active-low reset sets min_code_size to 8 and restarts decoding;
// the prefix, suffix and stack memories are not cleared.
`default_nettype none
module gif_lzw_decoder #(
    parameter int unsigned MAX_CODE_BITS = 12,
    parameter int unsigned TABLE_DEPTH   = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [gld_pkg::CFG_W-1:0]  i_cfg_data,
    gld_in_if.sink                          i_req,
    gld_out_if.source                       o_res
);
    import gld_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    pending_seq;

    gld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.cmd),
        .i_res_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid)
    );

    logic [BYTE_W-1:0] r_byte;
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_byte <= i_req.data_byte;
    end
    assign pending_seq = 1'b0;

    gld_dpath #(.MAX_CODE_BITS(MAX_CODE_BITS), .TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (r_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign o_res.symbol       = result.symbol_valid ? result.symbol : '0;
    assign o_res.symbol_valid = result.symbol_valid | pending_seq;
    assign o_res.need_byte    = result.need_byte;
    assign o_res.end_of_image = result.end_of_image;
    assign o_res.error_flag   = result.error_flag;
endmodule
`default_nettype wire

>>> tb/gld_checker.sv
`default_nettype none
module gld_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gld_pkg::CFG_W-1:0] i_cfg_data,
    gld_in_if                              req,
    gld_out_if                             res,
    output int                             o_fail_count,
    output int                             o_pending
);
    import gld_pkg::*;

    localparam int WIDTH_CAP = 12;
    localparam int DEPTH     = 4096;

    // Decoder state as predicted.
    logic [CFG_W-1:0]  size_reg;
    logic [BUF_W-1:0]  bit_buf;
    logic [BCNT_W-1:0] bit_cnt;
    int                width;
    int                next_code;
    int                prev_code;
    logic [7:0]        prev_first;
    bit                after_clr;
    bit                done;
    logic [11:0]       prefix_mem [DEPTH];
    logic [7:0]        suffix_mem [DEPTH];
    logic [7:0]        stack_mem  [DEPTH];
    int                stack_ptr;

    t_result expected_results[$];

    function automatic int eff_size();
        if (size_reg < MIN_SIZE) return MIN_SIZE;
        if (size_reg > MAX_SIZE) return MAX_SIZE;
        return size_reg;
    endfunction

    task automatic restart_decoder();
        bit_buf    = '0;
        bit_cnt    = '0;
        width      = eff_size() + 1;
        next_code  = (1 << eff_size()) + 2;
        prev_code  = 0;
        prev_first = '0;
        after_clr  = 1'b1;
        done       = 1'b0;
        stack_ptr  = 0;
    endtask

    task automatic push_symbol(input int v);
        if (stack_ptr < DEPTH) begin
            stack_mem[stack_ptr] = v[7:0];
            stack_ptr++;
        end
    endtask

    // Walk the prefix chain, pushing suffixes in reverse order.
    task automatic expand_chain(input int code, input int clr, output logic [7:0] first);
        int x;
        int guard;
        x = code;
        guard = 0;
        while (x > clr + 1 && x < DEPTH && guard < DEPTH) begin
            push_symbol(suffix_mem[x]);
            x = prefix_mem[x];
            guard++;
        end
        push_symbol(x);
        first = x[7:0];
    endtask

    task automatic take_code(input int c, output bit bad);
        int         clr;
        logic [7:0] first;
        clr = 1 << eff_size();
        bad = 1'b0;
        if (c == clr) begin
            width     = eff_size() + 1;
            next_code = clr + 2;
            after_clr = 1'b1;
        end else if (c == clr + 1) begin
            done = 1'b1;
        end else if (after_clr) begin
            if (c > clr) begin
                bad = 1'b1;
            end else begin
                push_symbol(c);
                prev_code  = c;
                prev_first = c[7:0];
                after_clr  = 1'b0;
            end
        end else if (c > next_code || c >= DEPTH) begin
            bad = 1'b1;
        end else begin
            if (c == next_code) begin
                push_symbol(prev_first);
                expand_chain(prev_code, clr, first);
            end else begin
                expand_chain(c, clr, first);
            end
            if (next_code < DEPTH) begin
                prefix_mem[next_code] = prev_code[11:0];
                suffix_mem[next_code] = first;
                next_code++;
                if (next_code == (1 << width) && width < WIDTH_CAP) width++;
            end
            prev_code  = c & 12'hFFF;
            prev_first = first;
        end
    endtask

    task automatic decode_request(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
                                  output t_result r);
        bit      err;
        bit      bad;
        int      c;
        int unsigned acc;
        err = 1'b0;
        r   = '0;
        if (cmd == CMD_FEED) begin
            if (!done) begin
                if (bit_cnt >= width) begin
                    err = 1'b1;
                end else begin
                    acc     = bit_buf | (32'(data) << bit_cnt);
                    bit_buf = acc[BUF_W-1:0];
                    bit_cnt = bit_cnt + 5'd8;
                end
            end
        end else begin
            while (stack_ptr == 0 && !done && bit_cnt >= width) begin
                c       = int'(bit_buf) & ((1 << width) - 1);
                bit_buf = bit_buf >> width;
                bit_cnt = bit_cnt - 5'(width);
                take_code(c, bad);
                if (bad) err = 1'b1;
            end
            if (stack_ptr > 0) begin
                stack_ptr--;
                r.symbol       = stack_mem[stack_ptr];
                r.symbol_valid = 1'b1;
            end
        end
        r.need_byte    = !done && stack_ptr == 0 && bit_cnt < width;
        r.end_of_image = done && stack_ptr == 0;
        r.error_flag   = err;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result r;
        t_result w;
        if (!i_rst_n) begin
            size_reg = 4'd8;
            restart_decoder();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                size_reg = i_cfg_data;
                restart_decoder();
            end
            if (req.valid && req.ready) begin
                decode_request(req.cmd, req.data_byte, r);
                expected_results.push_back(r);
            end
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (res.symbol != w.symbol) report("symbol", res.symbol, w.symbol);
                    if (res.symbol_valid != w.symbol_valid)
                        report("symbol_valid", res.symbol_valid, w.symbol_valid);
                    if (res.need_byte != w.need_byte)
                        report("need_byte", res.need_byte, w.need_byte);
                    if (res.end_of_image != w.end_of_image)
                        report("end_of_image", res.end_of_image, w.end_of_image);
                    if (res.error_flag != w.error_flag)
                        report("error_flag", res.error_flag, w.error_flag);
                end
            end
        end
        o_pending = expected_results.size();
    end
endmodule
`default_nettype wire

>>> tb/tb_gif_lzw_decoder.sv
`default_nettype none
module tb_gif_lzw_decoder;
    import gld_pkg::*;

    localparam int RANDOM_ITEMS = 1950;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_data;

    gld_in_if  req_if ();
    gld_out_if res_if ();

    int fail_count;
    int pending;

    // Stimulus bookkeeping
    int  item_count;
    int  stream_count;
    int  symbol_count;
    int  error_count;
    int  eoi_count;
    int  send_idle;
    int  recv_idle;
    bit  last_need;
    bit  last_eoi;

    gif_lzw_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    gld_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .req          (req_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(12 * 900000);
        $display("Timeout waiting for the decoder");
        $display("Some tests failed");
        $finish;
    end

    // Receiver stalls at random, rate set by the current phase.
    initial res_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Issue one request, hold it until accepted, then wait for its result.
    // The next choice of feed or pull hangs on need_byte, so every request
    // is answered before the following one goes out.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.cmd       <= cmd;
        req_if.data_byte <= data;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        req_if.valid <= 1'b0;
        item_count++;
        @(posedge i_clk);
        while (!(res_if.valid && res_if.ready)) @(posedge i_clk);
        last_need = res_if.need_byte;
        last_eoi  = res_if.end_of_image;
        if (res_if.symbol_valid) symbol_count++;
        if (res_if.error_flag) error_count++;
        if (res_if.end_of_image) eoi_count++;
    endtask

    // Restart the decoder with a new minimum code size; only ever done idle.
    task automatic write_size(input logic [CFG_W-1:0] v);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        last_need = 1'b1;
        last_eoi  = 1'b0;
    endtask

    function automatic int clamp_size(input logic [CFG_W-1:0] v);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > MAX_SIZE) return MAX_SIZE;
        return v;
    endfunction

    // LZW-encode a symbol string into GIF code-stream bytes: clear first,
    // end-of-information last, widths tracked as the decoder grows them.
    task automatic encode_stream(input int msz, input int syms[$],
                                 output logic [7:0] bytes[$]);
        int   codes[$];
        int   dict[int];
        int   clr;
        int   nf;
        int   cur;
        int   key;
        int   w;
        int   dnf;
        bit   first;
        bit   bits[$];
        logic [7:0] b;
        clr = 1 << msz;
        nf  = clr + 2;
        codes.push_back(clr);
        cur = syms[0];
        for (int i = 1; i < syms.size(); i++) begin
            key = cur * 256 + syms[i];
            if (dict.exists(key)) begin
                cur = dict[key];
            end else begin
                codes.push_back(cur);
                if (nf < 4096) begin
                    dict[key] = nf;
                    nf++;
                end
                cur = syms[i];
            end
        end
        codes.push_back(cur);
        codes.push_back(clr + 1);
        w     = msz + 1;
        dnf   = clr + 2;
        first = 1'b1;
        foreach (codes[k]) begin
            for (int j = 0; j < w; j++) bits.push_back((codes[k] >> j) & 1);
            if (codes[k] == clr) begin
                w     = msz + 1;
                dnf   = clr + 2;
                first = 1'b1;
            end else if (codes[k] != clr + 1) begin
                if (first) begin
                    first = 1'b0;
                end else if (dnf < 4096) begin
                    dnf++;
                    if (dnf == (1 << w) && w < 12) w++;
                end
            end
        end
        // Pad the last byte with random bits.
        while (bits.size() % 8 != 0) bits.push_back($urandom_range(1));
        bytes.delete();
        for (int i = 0; i < bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) b[j] = bits[i + j];
            bytes.push_back(b);
        end
    endtask

    // Play one code stream: feed while the decoder wants bytes, otherwise
    // pull; a share of requests is random noise.
    task automatic play_stream(input logic [CFG_W-1:0] size_val, input int syms[$],
                               input int noise_pct);
        logic [7:0] bytes[$];
        int         guard;
        int         limit;
        write_size(size_val);
        stream_count++;
        encode_stream(clamp_size(size_val), syms, bytes);
        limit = 4 * (bytes.size() + syms.size()) + 20;
        guard = 0;
        while (!last_eoi && guard < limit) begin
            guard++;
            if ($urandom_range(99) < noise_pct) begin
                send_request($urandom_range(1), $urandom_range(255));
            end else if (last_need) begin
                if (bytes.size() == 0) break;
                send_request(CMD_FEED, bytes.pop_front());
            end else begin
                send_request(CMD_PULL, 8'h00);
            end
        end
        // Past the end: feeds are ignored, pulls find nothing.
        if (last_eoi) begin
            send_request(CMD_FEED, $urandom_range(255));
            send_request(CMD_PULL, 8'h00);
        end
    endtask

    initial begin
        int syms[$];
        int msz;
        int n;
        logic [CFG_W-1:0] sv;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_FEED;
        req_if.data_byte = '0;
        item_count   = 0;
        stream_count = 0;
        symbol_count = 0;
        error_count  = 0;
        eoi_count    = 0;
        send_idle    = 29;
        recv_idle    = 52;
        last_need    = 1'b1;
        last_eoi     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of the symbol range and a repeated-symbol run
        // that hits the code not yet in the table.
        syms = '{0, 255, 255, 255};
        play_stream(4'd8, syms, 0);
        // Smallest size, written as an out-of-range value.
        syms = '{0, 3, 3, 3, 1};
        play_stream(4'd0, syms, 0);
        // Refused feed: a third byte while a whole code is still buffered,
        // then a pull, with the largest out-of-range size.
        write_size(4'd15);
        send_request(CMD_PULL, 8'h00);
        send_request(CMD_FEED, 8'h00);
        send_request(CMD_FEED, 8'hFF);
        send_request(CMD_FEED, 8'hA5);
        send_request(CMD_PULL, 8'h00);
        // Clear code followed at once by end-of-information.
        write_size(4'd2);
        send_request(CMD_FEED, 8'h2C);
        send_request(CMD_PULL, 8'h00);
        send_request(CMD_PULL, 8'h00);

        // Random: mostly well-formed streams, some pure noise.
        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            case (item_count * 3 / RANDOM_ITEMS)
                0: begin
                    send_idle = 29;
                    recv_idle = 52;
                end
                1: begin
                    send_idle = 52;
                    recv_idle = 29;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            sv = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 2));
            msz = clamp_size(sv);
            if ($urandom_range(4) == 0) begin
                write_size(sv);
                stream_count++;
                repeat ($urandom_range(40, 10))
                    send_request($urandom_range(1), $urandom_range(255));
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(30, 1);
                syms.delete();
                repeat (n) syms.push_back($urandom_range((1 << msz) - 1));
                play_stream(sv, syms, ($urandom_range(3) == 0) ? 8 : 0);
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d code streams at sizes 2 to 8 with out-of-range writes.",
                 stream_count);
        $display("Saw %0d symbols, %0d error flags and %0d end-of-image results.",
                 symbol_count, error_count, eoi_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
